// ----- hw/rtl/nsf_pkg.sv -----
// nsf_pkg: shared types and constants for the nested span flattener
// used by nsf_front, nsf_back and nested_span_flattener; no dependencies

package nsf_pkg;

    localparam int POS_W           = 32;
    localparam int TOK_W           = 16;
    localparam int TDATA_W         = 80;
    localparam int ENTRY_W         = POS_W + TOK_W;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [POS_W-1:0] END_OF_DOC = 32'hFFFF_FFFF;

    // command codes carried in s_tuser
    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_FINISH  = 1'b1;

    typedef struct packed {
        logic             is_finish;
        logic [POS_W-1:0] cap_start;
        logic [POS_W-1:0] cap_end;
        logic [TOK_W-1:0] cap_token;
    } nsf_item_t;

    typedef struct packed {
        logic [TOK_W-1:0] run_token;
        logic [POS_W-1:0] run_end;
        logic [POS_W-1:0] run_start;
    } nsf_run_t;

endpackage

// ----- hw/rtl/nsf_ram.sv -----
// nsf_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module nsf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/nsf_front.sv -----
// nsf_front: input transfer intake, command classification and a two-entry item queue
// depends on nsf_pkg

module nsf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nsf_pkg::TDATA_W-1:0]    s_tdata,
    input  logic                           s_tuser,
    output logic                           item_valid,
    input  logic                           item_ready,
    output nsf_pkg::nsf_item_t             item
);

    nsf_pkg::nsf_item_t slot_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         fill_reg, fill_next;
    nsf_pkg::nsf_item_t in_item;
    logic               push, pop;

    always_comb begin
        in_item.is_finish = (s_tuser == nsf_pkg::CMD_FINISH);
        in_item.cap_start = s_tdata[31:0];
        in_item.cap_end   = s_tdata[63:32];
        in_item.cap_token = s_tdata[79:64];
    end

    assign s_tready   = (fill_reg != 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/nsf_back.sv -----
// nsf_back: open-range stack, frontier and run emission with last-run marking
// depends on nsf_pkg and nsf_ram

module nsf_back #(
    parameter int STACK_DEPTH = nsf_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  nsf_pkg::nsf_item_t          item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nsf_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_FLUSH
    } state_t;

    state_t                         state_reg, state_next;
    nsf_pkg::nsf_item_t             cur_reg, cur_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [nsf_pkg::POS_W-1:0]      frontier_reg, frontier_next;
    logic [nsf_pkg::POS_W-1:0]      top_end_reg, top_end_next;
    logic [nsf_pkg::TOK_W-1:0]      top_tok_reg, top_tok_next;
    logic                           stale_reg, stale_next;
    nsf_pkg::nsf_run_t              pend_reg, pend_next;
    logic                           pend_valid_reg, pend_valid_next;
    nsf_pkg::nsf_run_t              out_reg, out_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr, ram_rd_addr;
    logic [nsf_pkg::ENTRY_W-1:0]    ram_wr_data, ram_rd_data;
    logic [CW-1:0]                  cnt_m1, cnt_m2;

    logic [nsf_pkg::POS_W-1:0]      top_end, limit;
    logic [nsf_pkg::TOK_W-1:0]      top_tok;
    logic                           has_top, out_free, flush_done;
    logic                           emit;
    nsf_pkg::nsf_run_t              emit_run;

    // the entry below the top is always being read, so a pop hands the new top next cycle
    assign cnt_m1      = cnt_reg - CW'(1);
    assign cnt_m2      = cnt_reg - CW'(2);
    assign ram_rd_addr = cnt_m2[AW-1:0];

    nsf_ram #(
        .WIDTH (nsf_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign top_end    = stale_reg ? ram_rd_data[nsf_pkg::ENTRY_W-1 -: nsf_pkg::POS_W]
                                  : top_end_reg;
    assign top_tok    = stale_reg ? ram_rd_data[nsf_pkg::TOK_W-1:0] : top_tok_reg;
    assign has_top    = (cnt_reg != '0);
    assign limit      = cur_reg.is_finish ? nsf_pkg::END_OF_DOC : cur_reg.cap_start;
    assign out_free   = !out_valid_reg || m_tready;
    assign flush_done = !pend_valid_reg || out_free;
    assign item_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FLUSH) && flush_done);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        frontier_next   = frontier_reg;
        top_end_next    = top_end;
        top_tok_next    = top_tok;
        stale_next      = 1'b0;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cnt_m1[AW-1:0];
        ram_wr_data     = {top_end, top_tok};
        emit            = 1'b0;
        emit_run        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    cur_next   = item;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    if (has_top && (top_end <= limit)) begin
                        // innermost range closes
                        emit_run = '{run_token: top_tok, run_end: top_end,
                                     run_start: frontier_reg};
                        emit     = (frontier_reg < top_end);
                        if (top_end > frontier_reg) begin
                            frontier_next = top_end;
                        end
                        cnt_next   = cnt_m1;
                        stale_next = 1'b1;
                    end else if (cur_reg.is_finish) begin
                        frontier_next = '0;
                        cnt_next      = '0;
                        state_next    = ST_FLUSH;
                    end else if (has_top && (top_end == cur_reg.cap_end)
                                 && (frontier_reg == cur_reg.cap_start)) begin
                        // same range as the innermost open one: first one wins
                        state_next = ST_FLUSH;
                    end else begin
                        if (has_top) begin
                            emit_run = '{run_token: top_tok, run_end: cur_reg.cap_start,
                                         run_start: frontier_reg};
                            emit     = (frontier_reg < cur_reg.cap_start);
                        end
                        if (frontier_reg < cur_reg.cap_start) begin
                            frontier_next = cur_reg.cap_start;
                        end
                        if (cnt_reg < CW'(STACK_DEPTH)) begin
                            ram_wr_en    = has_top;
                            top_end_next = cur_reg.cap_end;
                            top_tok_next = cur_reg.cap_token;
                            cnt_next     = cnt_reg + CW'(1);
                        end
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (flush_done) begin
                    if (pend_valid_reg) begin
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    if (item_valid) begin
                        cur_next   = item;
                        state_next = ST_CLOSE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new run pushes the held one out, which is then known not to be the last
        if (emit) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = emit_run;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            frontier_reg   <= '0;
            stale_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            frontier_reg   <= frontier_next;
            stale_reg      <= stale_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cur_reg      <= cur_next;
        top_end_reg  <= top_end_next;
        top_tok_reg  <= top_tok_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- hw/rtl/nested_span_flattener.sv -----
// nested_span_flattener: top level, turns nested capture ranges into flat runs
// depends on nsf_pkg, nsf_front, nsf_back and nsf_ram
//
//   channel  | dir | tdata fields (low bit up)                  | side fields
//   ---------+-----+--------------------------------------------+----------------------
//   s_       | in  | capture_start, capture_end, capture_token  | tuser = command
//   m_       | out | run_start, run_end, run_token              | tlast = last_run
//
// a capture pops each closed range in turn, then decides and pushes, and the last run
// is marked in the flush state, which overlaps the start of the next item; a finish
// pops every open range, then clears the stack and the frontier and marks the final run
// the stack ram's registered read paces it: one pop and one run per cycle while m_ is free
// reset (aresetn low, synchronous) empties the stack, the queue and the output
// register and zeroes the frontier; no clearing pass is needed
// a stalled m_ side holds the back end while the front queue still takes two transfers

module nested_span_flattener #(
    parameter int STACK_DEPTH = nsf_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // capture input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nsf_pkg::TDATA_W-1:0] s_tdata,   // capture_start, capture_end, capture_token
    input  logic                        s_tuser,   // command
    // flat run output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nsf_pkg::TDATA_W-1:0] m_tdata,   // run_start, run_end, run_token
    output logic                        m_tlast    // last_run
);

    // classified items waiting for the back end
    logic               item_valid;
    logic               item_ready;
    nsf_pkg::nsf_item_t item;

    // front end: takes transfers and queues them, so intake runs on during a stall
    nsf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // back end: stack walk, frontier tracking and the output register
    nsf_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- test/nsf_run_checker.sv -----
`timescale 1ns / 100ps
// nsf_run_checker: watches both stream channels of the span flattener, predicts the flat
// runs of every capture transfer and compares them with the runs that leave the block
// depends on nsf_pkg for widths, command codes and the run layout

module nsf_run_checker #(
    parameter int STACK_DEPTH = nsf_pkg::STACK_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [nsf_pkg::TDATA_W-1:0] s_tdata,   // capture_start, capture_end, capture_token
    input  logic                        s_tuser,   // command
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [nsf_pkg::TDATA_W-1:0] m_tdata,   // run_start, run_end, run_token
    input  logic                        m_tlast,   // last_run
    output int unsigned                 mismatch_count,
    output int unsigned                 runs_pending
);

    typedef struct packed {
        logic [nsf_pkg::POS_W-1:0] lo;
        logic [nsf_pkg::POS_W-1:0] hi;
        logic [nsf_pkg::TOK_W-1:0] tok;
        logic                      last;
    } flat_run_t;

    flat_run_t                 runs_due[$];
    logic [nsf_pkg::POS_W-1:0] span_end [STACK_DEPTH];
    logic [nsf_pkg::TOK_W-1:0] span_tok [STACK_DEPTH];
    int unsigned               span_depth;
    logic [nsf_pkg::POS_W-1:0] emitted_upto;

    task report_mismatch(input string what, input logic [nsf_pkg::POS_W-1:0] got,
                         input logic [nsf_pkg::POS_W-1:0] want);
        $display("nsf check at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // empty runs are dropped
    function void emit_run(input logic [nsf_pkg::POS_W-1:0] lo,
                           input logic [nsf_pkg::POS_W-1:0] hi,
                           input logic [nsf_pkg::TOK_W-1:0] tok);
        flat_run_t r;
        if (lo >= hi)
            return;
        r.lo   = lo;
        r.hi   = hi;
        r.tok  = tok;
        r.last = 1'b0;
        runs_due.push_back(r);
    endfunction

    // pop every innermost span ending at or before limit
    function void close_spans(input logic [nsf_pkg::POS_W-1:0] limit);
        while (span_depth > 0 && span_end[span_depth-1] <= limit) begin
            emit_run(emitted_upto, span_end[span_depth-1], span_tok[span_depth-1]);
            if (span_end[span_depth-1] > emitted_upto)
                emitted_upto = span_end[span_depth-1];
            span_depth--;
        end
    endfunction

    function void open_span(input logic [nsf_pkg::POS_W-1:0] lo,
                            input logic [nsf_pkg::POS_W-1:0] hi,
                            input logic [nsf_pkg::TOK_W-1:0] tok);
        close_spans(lo);
        // same range as the innermost open one: first pattern wins
        if (span_depth > 0 && span_end[span_depth-1] == hi && emitted_upto == lo)
            return;
        if (span_depth > 0)
            emit_run(emitted_upto, lo, span_tok[span_depth-1]);
        if (emitted_upto < lo)
            emitted_upto = lo;
        // full stack: the capture still emits but is not kept
        if (span_depth >= STACK_DEPTH)
            return;
        span_end[span_depth] = hi;
        span_tok[span_depth] = tok;
        span_depth++;
    endfunction

    function void flatten_step(input logic cmd, input logic [nsf_pkg::POS_W-1:0] lo,
                               input logic [nsf_pkg::POS_W-1:0] hi,
                               input logic [nsf_pkg::TOK_W-1:0] tok);
        int unsigned before_n;
        flat_run_t   tail;
        before_n = runs_due.size();
        if (cmd == nsf_pkg::CMD_FINISH) begin
            close_spans(nsf_pkg::END_OF_DOC);
            span_depth   = 0;
            emitted_upto = '0;
        end else begin
            open_span(lo, hi, tok);
        end
        if (runs_due.size() > before_n) begin
            tail      = runs_due.pop_back();
            tail.last = 1'b1;
            runs_due.push_back(tail);
        end
    endfunction

    always @(posedge aclk) begin
        flat_run_t         want;
        nsf_pkg::nsf_run_t got;
        if (!aresetn) begin
            span_depth     = 0;
            emitted_upto   = '0;
            mismatch_count = 0;
            runs_due.delete();
        end else begin
            // a run leaving now belongs to an earlier capture, so check before predicting
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (runs_due.size() == 0) begin
                    report_mismatch("run with nothing due, start", got.run_start, '0);
                end else begin
                    want = runs_due.pop_front();
                    if (got.run_start !== want.lo)
                        report_mismatch("run_start", got.run_start, want.lo);
                    if (got.run_end !== want.hi)
                        report_mismatch("run_end", got.run_end, want.hi);
                    if (got.run_token !== want.tok)
                        report_mismatch("run_token", 32'(got.run_token), 32'(want.tok));
                    if (m_tlast !== want.last)
                        report_mismatch("last_run", 32'(m_tlast), 32'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                flatten_step(s_tuser, s_tdata[nsf_pkg::POS_W-1:0],
                             s_tdata[2*nsf_pkg::POS_W-1:nsf_pkg::POS_W],
                             s_tdata[2*nsf_pkg::POS_W+nsf_pkg::TOK_W-1:2*nsf_pkg::POS_W]);
        end
        runs_pending = runs_due.size();
    end

endmodule

// ----- test/tb_nested_span_flattener.sv -----
`timescale 1ns / 100ps
// tb_nested_span_flattener: drives captures and finish commands into the span flattener
// with random idling on both sides; depends on nsf_pkg, the block and nsf_run_checker

module tb_nested_span_flattener;

    localparam int          DEPTH      = nsf_pkg::STACK_DEPTH_DEF;
    localparam int unsigned CYCLE_CAP  = 1_000_000;
    localparam int          HOLD_LEN   = 400;   // long receiver hold-off, in cycles
    localparam int          DRAIN_TAIL = 100;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [nsf_pkg::TDATA_W-1:0] s_tdata  = '0;
    logic                        s_tuser  = nsf_pkg::CMD_CAPTURE;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [nsf_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;

    int unsigned mismatch_count;
    int unsigned runs_pending;
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int          hold_left    = 0;
    int unsigned hold_reqs    = 0;
    int unsigned hold_seen    = 0;

    always #6 aclk = ~aclk;

    nested_span_flattener #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    nsf_run_checker #(
        .STACK_DEPTH(DEPTH)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .runs_pending  (runs_pending)
    );

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("nested_span_flattener: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted here when asked for
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_left = HOLD_LEN;
            hold_seen = hold_reqs;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // one input transfer; random gaps before it, valid stays up into the next item
    task automatic offer_item(input logic cmd, input logic [nsf_pkg::POS_W-1:0] lo,
                              input logic [nsf_pkg::POS_W-1:0] hi,
                              input logic [nsf_pkg::TOK_W-1:0] tok);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tok, hi, lo};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic capture(input logic [nsf_pkg::POS_W-1:0] lo,
                           input logic [nsf_pkg::POS_W-1:0] hi,
                           input logic [nsf_pkg::TOK_W-1:0] tok);
        offer_item(nsf_pkg::CMD_CAPTURE, lo, hi, tok);
    endtask

    // the payload of a finish is ignored, so it carries random bits
    task automatic finish_doc();
        offer_item(nsf_pkg::CMD_FINISH, $urandom, $urandom,
                   nsf_pkg::TOK_W'($urandom_range(0, 65535)));
    endtask

    // sender stops until every predicted run has left the block
    task automatic drain_runs();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (runs_pending != 0)
            @(posedge aclk);
    endtask

    // one document: mostly properly nested captures in order, some repeats of the
    // previous range and some random ranges, closed by a finish
    task automatic send_document(input int n);
        longint unsigned           pos;
        longint unsigned           stop;
        logic [nsf_pkg::POS_W-1:0] ends [16];
        int                        depth;
        int                        pick;
        logic [nsf_pkg::POS_W-1:0] prev_lo;
        logic [nsf_pkg::POS_W-1:0] prev_hi;
        bit                        have_prev;
        depth     = 0;
        have_prev = 1'b0;
        prev_lo   = '0;
        prev_hi   = '0;
        case ($urandom_range(0, 3))
            0: pos = 0;
            1: pos = $urandom_range(0, 4096);
            2: pos = $urandom;
            default: pos = 32'hFFFF_FF00;
        endcase
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                capture($urandom, $urandom, nsf_pkg::TOK_W'($urandom_range(0, 65535)));
            end else if (pick < 16 && have_prev) begin
                capture(prev_lo, prev_hi, nsf_pkg::TOK_W'($urandom_range(0, 65535)));
            end else begin
                pos += $urandom_range(0, 6);
                // leave ranges that ended, and now and then skip to a parent's end
                while (depth > 0 && (ends[depth-1] <= pos || $urandom_range(0, 3) == 0)) begin
                    if (ends[depth-1] > pos)
                        pos = ends[depth-1];
                    depth--;
                end
                stop = pos + $urandom_range(0, 40);
                if (depth > 0 && stop > ends[depth-1])
                    stop = ends[depth-1];
                if (stop > 64'hFFFF_FFFF)
                    stop = 64'hFFFF_FFFF;
                if (pos > 64'hFFFF_FFFF)
                    pos = 64'hFFFF_FFFF;
                if (depth < 16) begin
                    ends[depth] = stop[nsf_pkg::POS_W-1:0];
                    depth++;
                end
                prev_lo   = pos[nsf_pkg::POS_W-1:0];
                prev_hi   = stop[nsf_pkg::POS_W-1:0];
                have_prev = 1'b1;
                capture(prev_lo, prev_hi, nsf_pkg::TOK_W'($urandom_range(0, 65535)));
            end
        end
        finish_doc();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase one: sender idles with 30 percent odds, receiver with 88
        src_idle_pct = 30;
        snk_idle_pct = 88;

        // directed: extremes, first-pattern-wins, reversed and empty ranges
        finish_doc();                                           // flush of an empty stack
        capture(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);        // whole address space
        capture(32'h0000_0000, 32'hFFFF_FFFF, 16'h1234);        // same range, ignored
        capture(32'd10, 32'd20, 16'h0000);                      // parent part before it
        capture(32'd20, 32'd30, 16'hA5A5);                      // closes the previous one
        capture(32'd40, 32'd35, 16'h5A5A);                      // reversed range
        capture(32'd50, 32'd60, 16'h0001);                      // reversed one closes empty
        finish_doc();                                           // run up to the top offset
        capture(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8001);        // empty at the top
        capture(32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h0002);        // start below the frontier
        finish_doc();                                           // all runs empty
        capture(32'h8000_0000, 32'hC000_0000, 16'h00FF);
        capture(32'h9000_0000, 32'hA000_0000, 16'hFF00);
        capture(32'h9000_0000, 32'hA000_0000, 16'h7777);        // same range, ignored
        capture(32'hA000_0000, 32'hB000_0000, 16'h3C3C);        // adjacent sibling
        capture(32'hD000_0000, 32'hE000_0000, 16'hC3C3);        // closes two levels
        finish_doc();
        drain_runs();

        do begin
            send_document($urandom_range(3, 12));
        end while (items_sent < 26);
        drain_runs();

        // phase two: the other way round
        src_idle_pct = 88;
        snk_idle_pct = 30;
        do begin
            send_document($urandom_range(3, 12));
        end while (items_sent < 38);
        drain_runs();

        // phase three: no idling
        src_idle_pct = 0;
        snk_idle_pct = 0;
        do begin
            send_document($urandom_range(3, 12));
        end while (items_sent < 48);

        // receiver holds off while a nest deeper than the stack streams in; the extra
        // captures hit a full stack and the finish then flushes 64 runs
        hold_reqs++;
        for (int i = 0; i < DEPTH + 4; i++)
            capture(32'd5000 + i, 32'd9000 - i, nsf_pkg::TOK_W'($urandom_range(0, 65535)));
        finish_doc();
        drain_runs();

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0 && runs_pending == 0) begin
            $display("nested_span_flattener: match");
        end else begin
            $display("nested_span_flattener: mismatch");
        end
        $finish;
    end

endmodule
